@@ hw/rtl/pomj_pkg.sv @@
// Shared constants, word types and iterative unit command types for the polyline offset block.
`default_nettype none

package pomj_pkg;

  localparam int COORD_BITS = 16;          // saturation range of the offset coordinates
  localparam int FRAC_BITS  = 16;          // fraction bits of the unit normal
  localparam int UW         = 68;          // datapath width of the shared unit
  localparam int NW         = FRAC_BITS + 2; // Q2.FRAC normal component, signed
  localparam int CNT_W      = 7;           // iteration counter, holds UW - 1

  typedef enum logic [1:0] {
    ALU_MUL,
    ALU_DIV,
    ALU_SQRT
  } alu_op_t;

  typedef struct packed {
    logic                 start;
    alu_op_t              op;
    logic signed [UW-1:0] a;
    logic signed [UW-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic                 done;
    logic signed [UW-1:0] result;
  } alu_rsp_t;

  typedef struct packed {
    logic signed [15:0] vert_x;
    logic signed [15:0] vert_y;
    logic               end_of_line;
  } vert_t;

  typedef struct packed {
    logic signed [15:0] top_x;
    logic signed [15:0] top_y;
    logic signed [15:0] bottom_x;
    logic signed [15:0] bottom_y;
    logic               final_pair;
  } pair_t;

endpackage

`default_nettype wire

@@ hw/rtl/polyline_offset_miter_joiner.sv @@
// Top level: polyline offset with miter joins, sequencer around one shared iterative unit.
`default_nettype none

// Channel  Dir  Handshake            Word
// vert     in   in_valid / in_stall  vertex x, y, end_of_line flag
// pair     out  out_valid / out_stall top x/y, bottom x/y, final_pair flag
// cfg      in   cfg_we               line_width (full symbol width)
//
// A vertex takes least time when it is a first or repeated vertex, and most for a join
// with an end pair. The shared unit sets the time: each divide runs 68 one-bit steps,
// a square root 17 steps, a multiply one byte of the multiplier a cycle.
// Reset clears the vertex history and sets line_width to 2.
// in_stall stays high while a vertex is in work; a held result waits in the output
// register, and the next vertex is taken while it waits.

module polyline_offset_miter_joiner import pomj_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  vert_t      vert,
  output logic       out_valid,
  input  logic       out_stall,
  output pair_t      pair,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data
);

  localparam int PW = 18;               // offset point coordinate
  localparam int DW = PW + 1;           // difference of two offset points
  localparam int OW = 16 + FRAC_BITS + 2; // offset numerator
  localparam logic signed [UW-1:0] SAT_HI = (UW'(1) <<< (COORD_BITS - 1)) - UW'(1);
  localparam logic signed [UW-1:0] SAT_LO = -SAT_HI - UW'(1);

  typedef enum logic [4:0] {
    ST_IDLE, ST_DECIDE,
    ST_NRM_MX, ST_NRM_MY, ST_NRM_DV1, ST_NRM_SQ1, ST_NRM_DV2, ST_NRM_SQ2,
    ST_EO_CALC, ST_J_OFF,
    ST_J_M1, ST_J_M2, ST_J_M3, ST_J_M4, ST_J_CHK,
    ST_J_M5, ST_J_M6, ST_J_DVX, ST_J_M7, ST_J_M8, ST_J_DVY, ST_J_SIDE,
    ST_EMIT, ST_FINISH
  } state_t;

  // Saturate to the signed coordinate range.
  function automatic logic signed [15:0] sat_coord(input logic signed [UW-1:0] v);
    logic signed [UW-1:0] r;
    r = v;
    if (v > SAT_HI) r = SAT_HI;
    if (v < SAT_LO) r = SAT_LO;
    return r[15:0];
  endfunction

  // Offset one coordinate by n * t, truncated toward zero.
  function automatic logic signed [PW-1:0] off_coord(input logic signed [15:0] v,
                                                     input logic signed [NW-1:0] n,
                                                     input logic [6:0] t,
                                                     input logic neg);
    logic signed [NW+8:0] tprod;
    logic signed [OW-1:0] prod;
    logic signed [OW-1:0] num;
    tprod = n * $signed({1'b0, t});
    prod  = OW'(tprod);
    num   = (OW'(v) <<< FRAC_BITS) + (neg ? -prod : prod);
    if (num < 0) num = num + OW'((1 << FRAC_BITS) - 1);
    return PW'(num >>> FRAC_BITS);
  endfunction

  state_t state;
  logic   launched;

  // vertex history
  logic [1:0]         seen;
  logic signed [15:0] lvx, lvy, ovx, ovy;
  logic signed [15:0] vin_x, vin_y;
  logic               vin_eol;
  logic [7:0]         lw;

  // sequencing flags
  logic       rep_r, nrm_sel, eo_end, eo_s1, fin_cur, side;
  logic [2:0] k;

  // normals, offset points, wide temporaries, result pair
  logic signed [NW-1:0] s1, c1, s2, c2;
  logic signed [PW-1:0] p0x, p0y, p1x, p1y, p2x, p2y, p3x, p3y;
  logic signed [UW-1:0] acc_a, acc_b, acc_d, acc_u;
  logic signed [15:0]   tx, ty, bx, by;

  logic  out_v;
  pair_t pair_r;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  pomj_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // segment endpoints of the normal in work
  logic signed [15:0] nax, nay, nbx, nby;
  logic signed [16:0] ndx, ndy;
  logic signed [NW-1:0] nrm_r;

  assign nax   = nrm_sel ? lvx : ovx;
  assign nay   = nrm_sel ? lvy : ovy;
  assign nbx   = nrm_sel ? vin_x : lvx;
  assign nby   = nrm_sel ? vin_y : lvy;
  assign ndx   = {nbx[15], nbx} - {nax[15], nax};
  assign ndy   = {nby[15], nby} - {nay[15], nay};
  assign nrm_r = alu_rsp.result[NW-1:0];

  // offset segment edges of the side in work
  logic signed [DW-1:0] e1x, e1y, e2x, e2y, fx, fy;

  assign e1x = {p1x[PW-1], p1x} - {p0x[PW-1], p0x};
  assign e1y = {p1y[PW-1], p1y} - {p0y[PW-1], p0y};
  assign e2x = {p3x[PW-1], p3x} - {p2x[PW-1], p2x};
  assign e2y = {p3y[PW-1], p3y} - {p2y[PW-1], p2y};
  assign fx  = {p2x[PW-1], p2x} - {p0x[PW-1], p0x};
  assign fy  = {p2y[PW-1], p2y} - {p0y[PW-1], p0y};

  // one offset coordinate per cycle
  logic signed [15:0]   off_v;
  logic signed [NW-1:0] off_n;
  logic                 off_neg;
  logic signed [PW-1:0] off_val;

  always_comb begin
    off_v   = lvx;
    off_n   = s2;
    off_neg = 1'b0;
    if (state == ST_J_OFF) begin
      off_neg = side;
      case (k[2:1])
        2'd0:    begin off_v = k[0] ? ovy : ovx;     off_n = k[0] ? c1 : s1; end
        2'd1:    begin off_v = k[0] ? lvy : lvx;     off_n = k[0] ? c1 : s1; end
        2'd2:    begin off_v = k[0] ? lvy : lvx;     off_n = k[0] ? c2 : s2; end
        default: begin off_v = k[0] ? vin_y : vin_x; off_n = k[0] ? c2 : s2; end
      endcase
    end else begin
      off_neg = k[1];
      if (k[0]) begin
        off_v = eo_end ? vin_y : lvy;
        off_n = eo_s1 ? c1 : c2;
      end else begin
        off_v = eo_end ? vin_x : lvx;
        off_n = eo_s1 ? s1 : s2;
      end
    end
    off_val = off_coord(off_v, off_n, lw[7:1], off_neg);
  end

  // command to the shared unit, raised once per step
  always_comb begin
    alu_req.start = 1'b0;
    alu_req.op    = ALU_MUL;
    alu_req.a     = '0;
    alu_req.b     = '0;
    unique case (state)
      ST_NRM_MX:  begin alu_req.start = !launched; alu_req.a = UW'(ndx); alu_req.b = UW'(ndx); end
      ST_NRM_MY:  begin alu_req.start = !launched; alu_req.a = UW'(ndy); alu_req.b = UW'(ndy); end
      ST_NRM_DV1: begin
        alu_req.start = !launched; alu_req.op = ALU_DIV;
        alu_req.a = acc_b <<< (2 * FRAC_BITS); alu_req.b = acc_d;
      end
      ST_NRM_SQ1: begin alu_req.start = !launched; alu_req.op = ALU_SQRT; alu_req.a = acc_u; end
      ST_NRM_DV2: begin
        alu_req.start = !launched; alu_req.op = ALU_DIV;
        alu_req.a = acc_a <<< (2 * FRAC_BITS); alu_req.b = acc_d;
      end
      ST_NRM_SQ2: begin alu_req.start = !launched; alu_req.op = ALU_SQRT; alu_req.a = acc_u; end
      ST_J_M1:    begin alu_req.start = !launched; alu_req.a = UW'(e2x); alu_req.b = UW'(e1y); end
      ST_J_M2:    begin alu_req.start = !launched; alu_req.a = UW'(e1x); alu_req.b = UW'(e2y); end
      ST_J_M3:    begin alu_req.start = !launched; alu_req.a = UW'(e2x); alu_req.b = UW'(fy); end
      ST_J_M4:    begin alu_req.start = !launched; alu_req.a = UW'(e2y); alu_req.b = UW'(fx); end
      ST_J_M5:    begin alu_req.start = !launched; alu_req.a = acc_d; alu_req.b = UW'(p0x); end
      ST_J_M6:    begin alu_req.start = !launched; alu_req.a = acc_u; alu_req.b = UW'(e1x); end
      ST_J_DVX:   begin
        alu_req.start = !launched; alu_req.op = ALU_DIV; alu_req.a = acc_b; alu_req.b = acc_d;
      end
      ST_J_M7:    begin alu_req.start = !launched; alu_req.a = acc_d; alu_req.b = UW'(p0y); end
      ST_J_M8:    begin alu_req.start = !launched; alu_req.a = acc_u; alu_req.b = UW'(e1y); end
      ST_J_DVY:   begin
        alu_req.start = !launched; alu_req.op = ALU_DIV; alu_req.a = acc_b; alu_req.b = acc_d;
      end
      default:    begin end
    endcase
  end

  logic rep;
  logic out_free;

  assign rep      = (vin_x == lvx) && (vin_y == lvy);
  assign out_free = !out_v || !out_stall;
  assign in_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      launched <= 1'b0;
      seen     <= '0;
      lvx      <= '0;
      lvy      <= '0;
      ovx      <= '0;
      ovy      <= '0;
      lw       <= 8'd2;
      out_v    <= 1'b0;
    end else begin
      if (cfg_we) begin
        lw <= cfg_data;
      end
      // drop the held word once taken; a new word below overrides
      if (out_v && !out_stall) begin
        out_v <= 1'b0;
      end
      if (alu_req.start) begin
        launched <= 1'b1;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            vin_x   <= vert.vert_x;
            vin_y   <= vert.vert_y;
            vin_eol <= vert.end_of_line;
            state   <= ST_DECIDE;
          end
        end

        ST_DECIDE: begin
          if (seen == 2'd0) begin
            if (vin_eol) begin
              // lone vertex: degenerate pair
              tx <= vin_x; ty <= vin_y; bx <= vin_x; by <= vin_y;
              fin_cur <= 1'b1;
              state   <= ST_EMIT;
            end else begin
              lvx   <= vin_x;
              lvy   <= vin_y;
              seen  <= 2'd1;
              state <= ST_IDLE;
            end
          end else if (rep) begin
            if (!vin_eol) begin
              state <= ST_IDLE;
            end else if (seen == 2'd1) begin
              tx <= lvx; ty <= lvy; bx <= lvx; by <= lvy;
              fin_cur <= 1'b1;
              state   <= ST_EMIT;
            end else begin
              // closing repeat: end pair of the older segment
              rep_r   <= 1'b1;
              nrm_sel <= 1'b0;
              state   <= ST_NRM_MX;
            end
          end else begin
            rep_r   <= 1'b0;
            nrm_sel <= 1'b1;
            state   <= ST_NRM_MX;
          end
        end

        ST_NRM_MX: begin
          if (alu_rsp.done) begin
            acc_a <= alu_rsp.result; launched <= 1'b0; state <= ST_NRM_MY;
          end
        end
        ST_NRM_MY: begin
          if (alu_rsp.done) begin
            acc_b <= alu_rsp.result;
            acc_d <= acc_a + alu_rsp.result;
            launched <= 1'b0; state <= ST_NRM_DV1;
          end
        end
        ST_NRM_DV1: begin
          if (alu_rsp.done) begin
            acc_u <= alu_rsp.result; launched <= 1'b0; state <= ST_NRM_SQ1;
          end
        end
        ST_NRM_SQ1: begin
          if (alu_rsp.done) begin
            // sine takes the sign of -dy
            if (nrm_sel) s2 <= (ndy > 0) ? -nrm_r : nrm_r;
            else         s1 <= (ndy > 0) ? -nrm_r : nrm_r;
            launched <= 1'b0; state <= ST_NRM_DV2;
          end
        end
        ST_NRM_DV2: begin
          if (alu_rsp.done) begin
            acc_u <= alu_rsp.result; launched <= 1'b0; state <= ST_NRM_SQ2;
          end
        end
        ST_NRM_SQ2: begin
          if (alu_rsp.done) begin
            if (nrm_sel) c2 <= (ndx < 0) ? -nrm_r : nrm_r;
            else         c1 <= (ndx < 0) ? -nrm_r : nrm_r;
            launched <= 1'b0;
            k        <= '0;
            if (nrm_sel) begin
              if (seen == 2'd1) begin
                // start pair at the first vertex
                eo_end <= 1'b0; eo_s1 <= 1'b0; fin_cur <= 1'b0;
                state  <= ST_EO_CALC;
              end else begin
                nrm_sel <= 1'b0;
                state   <= ST_NRM_MX;
              end
            end else if (rep_r) begin
              eo_end <= 1'b0; eo_s1 <= 1'b1; fin_cur <= 1'b1;
              state  <= ST_EO_CALC;
            end else begin
              side  <= 1'b0;
              state <= ST_J_OFF;
            end
          end
        end

        ST_EO_CALC: begin
          case (k[1:0])
            2'd0:    tx <= sat_coord(UW'(off_val));
            2'd1:    ty <= sat_coord(UW'(off_val));
            2'd2:    bx <= sat_coord(UW'(off_val));
            default: by <= sat_coord(UW'(off_val));
          endcase
          k <= k + 1'b1;
          if (k[1:0] == 2'd3) begin
            state <= ST_EMIT;
          end
        end

        ST_J_OFF: begin
          case (k)
            3'd0:    p0x <= off_val;
            3'd1:    p0y <= off_val;
            3'd2:    p1x <= off_val;
            3'd3:    p1y <= off_val;
            3'd4:    p2x <= off_val;
            3'd5:    p2y <= off_val;
            3'd6:    p3x <= off_val;
            default: p3y <= off_val;
          endcase
          k <= k + 1'b1;
          if (k == 3'd7) begin
            state <= ST_J_M1;
          end
        end

        ST_J_M1: begin
          if (alu_rsp.done) begin
            acc_a <= alu_rsp.result; launched <= 1'b0; state <= ST_J_M2;
          end
        end
        ST_J_M2: begin
          if (alu_rsp.done) begin
            acc_d <= acc_a - alu_rsp.result; launched <= 1'b0; state <= ST_J_M3;
          end
        end
        ST_J_M3: begin
          if (alu_rsp.done) begin
            acc_a <= alu_rsp.result; launched <= 1'b0; state <= ST_J_M4;
          end
        end
        ST_J_M4: begin
          if (alu_rsp.done) begin
            acc_u <= acc_a - alu_rsp.result; launched <= 1'b0; state <= ST_J_CHK;
          end
        end
        ST_J_CHK: begin
          if (acc_d == '0) begin
            // parallel segments: keep the shared vertex offset
            if (side) begin
              bx <= sat_coord(UW'(p1x)); by <= sat_coord(UW'(p1y));
            end else begin
              tx <= sat_coord(UW'(p1x)); ty <= sat_coord(UW'(p1y));
            end
            state <= ST_J_SIDE;
          end else begin
            state <= ST_J_M5;
          end
        end
        ST_J_M5: begin
          if (alu_rsp.done) begin
            acc_a <= alu_rsp.result; launched <= 1'b0; state <= ST_J_M6;
          end
        end
        ST_J_M6: begin
          if (alu_rsp.done) begin
            acc_b <= acc_a + alu_rsp.result; launched <= 1'b0; state <= ST_J_DVX;
          end
        end
        ST_J_DVX: begin
          if (alu_rsp.done) begin
            if (side) bx <= sat_coord(alu_rsp.result);
            else      tx <= sat_coord(alu_rsp.result);
            launched <= 1'b0; state <= ST_J_M7;
          end
        end
        ST_J_M7: begin
          if (alu_rsp.done) begin
            acc_a <= alu_rsp.result; launched <= 1'b0; state <= ST_J_M8;
          end
        end
        ST_J_M8: begin
          if (alu_rsp.done) begin
            acc_b <= acc_a + alu_rsp.result; launched <= 1'b0; state <= ST_J_DVY;
          end
        end
        ST_J_DVY: begin
          if (alu_rsp.done) begin
            if (side) by <= sat_coord(alu_rsp.result);
            else      ty <= sat_coord(alu_rsp.result);
            launched <= 1'b0; state <= ST_J_SIDE;
          end
        end
        ST_J_SIDE: begin
          if (!side) begin
            side  <= 1'b1;
            k     <= '0;
            state <= ST_J_OFF;
          end else begin
            fin_cur <= 1'b0;
            state   <= ST_EMIT;
          end
        end

        ST_EMIT: begin
          if (out_free) begin
            pair_r <= '{top_x: tx, top_y: ty, bottom_x: bx, bottom_y: by,
                        final_pair: fin_cur};
            out_v  <= 1'b1;
            if (!fin_cur && vin_eol) begin
              // end pair at the closing vertex
              eo_end <= 1'b1; eo_s1 <= 1'b0; fin_cur <= 1'b1;
              k      <= '0;
              state  <= ST_EO_CALC;
            end else begin
              state <= ST_FINISH;
            end
          end
        end

        ST_FINISH: begin
          if (vin_eol) begin
            seen <= '0;
            lvx  <= '0; lvy <= '0; ovx <= '0; ovy <= '0;
          end else begin
            ovx  <= lvx;   ovy <= lvy;
            lvx  <= vin_x; lvy <= vin_y;
            seen <= 2'd2;
          end
          state <= ST_IDLE;
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = out_v;
  assign pair      = pair_r;

`ifndef ASSERT_OFF
  a_done_launched: assert property (@(posedge clk) disable iff (rst)
    alu_rsp.done |-> launched)
    else $error("unit finished without a pending step");

  a_start_gap: assert property (@(posedge clk) disable iff (rst)
    alu_req.start |=> !alu_rsp.done)
    else $error("unit finished right after a start");

  a_word_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_v) |-> $past(state == ST_EMIT))
    else $error("result word loaded outside the emit step");

  a_seen_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (seen != 2'd3))
    else $error("vertex count out of range");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/pomj_alu.sv @@
// Shared iterative unit: signed multiply by byte digits, signed divide, integer square root.
`default_nettype none

module pomj_alu import pomj_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  localparam logic [UW-1:0] SQ_TOP = UW'(1) << (2 * FRAC_BITS);

  logic                 busy;
  alu_op_t              op;
  logic                 neg;
  logic [UW-1:0]        ra;
  logic [UW-1:0]        rb;
  logic [UW-1:0]        acc;
  logic [UW:0]          rem;
  logic [CNT_W-1:0]     cnt;
  logic                 done;
  logic signed [UW-1:0] result;

  logic [UW-1:0] mag_a;
  logic [UW-1:0] mag_b;
  logic [UW-1:0] mul_part;
  logic [UW-1:0] mul_acc;
  logic [UW:0]   div_trial;
  logic          div_ge;
  logic [UW:0]   div_sub;
  logic [UW-1:0] div_quo;
  logic [UW-1:0] sq_sum;
  logic          sq_ge;
  logic [UW-1:0] sq_next;

  assign mag_a     = req.a[UW-1] ? UW'(-req.a) : UW'(req.a);
  assign mag_b     = req.b[UW-1] ? UW'(-req.b) : UW'(req.b);
  assign mul_part  = ra * UW'(rb[7:0]);
  assign mul_acc   = acc + mul_part;
  assign div_trial = {rem[UW-1:0], ra[UW-1]};
  assign div_ge    = div_trial >= {1'b0, rb};
  assign div_sub   = div_trial - {1'b0, rb};
  assign div_quo   = {ra[UW-2:0], div_ge};
  assign sq_sum    = acc + rb;
  assign sq_ge     = ra >= sq_sum;
  assign sq_next   = sq_ge ? (acc >> 1) + rb : acc >> 1;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        op   <= req.op;
        cnt  <= '0;
        acc  <= '0;
        rem  <= '0;
        if (req.op == ALU_SQRT) begin
          ra  <= UW'(req.a);
          rb  <= SQ_TOP;
          neg <= 1'b0;
        end else begin
          ra  <= mag_a;
          rb  <= mag_b;
          neg <= req.a[UW-1] ^ req.b[UW-1];
        end
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        unique case (op)
          ALU_MUL: begin
            // one byte of the multiplier per cycle, stop once none is left
            acc <= mul_acc;
            ra  <= ra << 8;
            rb  <= rb >> 8;
            if (rb[UW-1:8] == '0) begin
              busy   <= 1'b0;
              done   <= 1'b1;
              result <= neg ? $signed(-mul_acc) : $signed(mul_acc);
            end
          end
          ALU_DIV: begin
            rem <= div_ge ? div_sub : div_trial;
            ra  <= div_quo;
            if (cnt == CNT_W'(UW - 1)) begin
              busy   <= 1'b0;
              done   <= 1'b1;
              result <= neg ? $signed(-div_quo) : $signed(div_quo);
            end
          end
          ALU_SQRT: begin
            if (sq_ge) begin
              ra <= ra - sq_sum;
            end
            acc <= sq_next;
            rb  <= rb >> 2;
            if (cnt == CNT_W'(FRAC_BITS)) begin
              busy   <= 1'b0;
              done   <= 1'b1;
              result <= $signed(sq_next);
            end
          end
          default: begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        endcase
      end
    end
  end

  assign rsp.done   = done;
  assign rsp.result = result;

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// Testbench for the polyline offset block: directed table, then random polylines, checked against a local predictor.
`timescale 1ns / 1ps

module tb;
  import pomj_pkg::*;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  vert_t      vert;
  logic       out_valid;
  logic       out_stall;
  pair_t      pair;
  logic       cfg_we;
  logic [7:0] cfg_data;

  polyline_offset_miter_joiner u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .vert(vert),
    .out_valid(out_valid), .out_stall(out_stall), .pair(pair),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  // Idle modes: none, sender gaps, receiver stalls, both.
  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  // Predictor state: a shadow of the block's vertex history and width register.
  logic [7:0]   pw_width;
  longint       pv_lx, pv_ly, pv_ox, pv_oy;
  int           pv_seen;
  pair_t        pairs_due[$];
  int           errors;
  idle_mode_t   idle_mode;
  bit           hold_recv;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Generous fixed limit: the slowest vertices plus long stalls, several times over.
  initial begin
    #20000000;
    $display("tb failed");
    $finish;
  end

  function automatic longint isqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  // One component of a unit vector, Q2.16, truncated toward zero.
  function automatic longint unit_part(longint d, longint unsigned s);
    longint unsigned m, q, rem;
    longint c;
    m = d < 0 ? -d : d;
    q = (m * m) / s;
    rem = (m * m) % s;
    for (int i = 0; i < 2 * FRAC_BITS; i++) begin
      rem <<= 1;
      q <<= 1;
      if (rem >= s) begin
        rem -= s;
        q |= 1;
      end
    end
    c = isqrt(q);
    return d < 0 ? -c : c;
  endfunction

  task automatic normal_of(input longint ax, ay, bx, by, output longint sn, cs);
    longint dx, dy;
    longint unsigned s;
    dx = bx - ax;
    dy = by - ay;
    s = dx * dx + dy * dy;
    sn = unit_part(-dy, s);
    cs = unit_part(dx, s);
  endtask

  function automatic longint shift_pt(longint v, longint n, longint side);
    longint t;
    t = longint'(pw_width >> 1);
    return (v * 65536 + side * n * t) / 65536;
  endfunction

  function automatic logic [15:0] clamp16(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic pair_t make_pair(longint tx, ty, bx, by, logic fin);
    pair_t p;
    p.top_x = clamp16(tx);
    p.top_y = clamp16(ty);
    p.bottom_x = clamp16(bx);
    p.bottom_y = clamp16(by);
    p.final_pair = fin;
    return p;
  endfunction

  function automatic pair_t offset_pair(longint vx, vy, sn, cs, logic fin);
    return make_pair(shift_pt(vx, sn, 1), shift_pt(vy, cs, 1),
                     shift_pt(vx, sn, -1), shift_pt(vy, cs, -1), fin);
  endfunction

  task automatic miter_side(input longint ax, ay, bx, by, cx, cy,
                            input longint s1, c1, s2, c2, side,
                            output longint jx, jy);
    longint p0x, p0y, p1x, p1y, p2x, p2y, p3x, p3y, d, du;
    p0x = shift_pt(ax, s1, side); p0y = shift_pt(ay, c1, side);
    p1x = shift_pt(bx, s1, side); p1y = shift_pt(by, c1, side);
    p2x = shift_pt(bx, s2, side); p2y = shift_pt(by, c2, side);
    p3x = shift_pt(cx, s2, side); p3y = shift_pt(cy, c2, side);
    d  = (p3x - p2x) * (p1y - p0y) - (p1x - p0x) * (p3y - p2y);
    du = (p3x - p2x) * (p2y - p0y) - (p3y - p2y) * (p2x - p0x);
    if (d == 0) begin
      // parallel segments: take the earlier segment's end offset
      jx = p1x;
      jy = p1y;
    end else begin
      jx = (p0x * d + du * (p1x - p0x)) / d;
      jy = (p0y * d + du * (p1y - p0y)) / d;
    end
  endtask

  // Advance the shadow by one vertex and queue the pairs it produces.
  task automatic predict_offsets(input vert_t v);
    longint vx, vy, s1, c1, s2, c2, tx, ty, bx, by;
    vx = v.vert_x;
    vy = v.vert_y;
    if (pv_seen == 0) begin
      if (v.end_of_line) begin
        pairs_due.push_back(make_pair(vx, vy, vx, vy, 1'b1));
      end else begin
        pv_lx = vx; pv_ly = vy; pv_seen = 1;
      end
      return;
    end
    if (vx == pv_lx && vy == pv_ly) begin
      // repeated vertex: skip, unless it closes the line
      if (v.end_of_line) begin
        if (pv_seen == 1) begin
          pairs_due.push_back(make_pair(pv_lx, pv_ly, pv_lx, pv_ly, 1'b1));
        end else begin
          normal_of(pv_ox, pv_oy, pv_lx, pv_ly, s1, c1);
          pairs_due.push_back(offset_pair(pv_lx, pv_ly, s1, c1, 1'b1));
        end
        pv_seen = 0; pv_lx = 0; pv_ly = 0; pv_ox = 0; pv_oy = 0;
      end
      return;
    end
    normal_of(pv_lx, pv_ly, vx, vy, s2, c2);
    if (pv_seen == 1) begin
      pairs_due.push_back(offset_pair(pv_lx, pv_ly, s2, c2, 1'b0));
    end else begin
      normal_of(pv_ox, pv_oy, pv_lx, pv_ly, s1, c1);
      miter_side(pv_ox, pv_oy, pv_lx, pv_ly, vx, vy, s1, c1, s2, c2, 1, tx, ty);
      miter_side(pv_ox, pv_oy, pv_lx, pv_ly, vx, vy, s1, c1, s2, c2, -1, bx, by);
      pairs_due.push_back(make_pair(tx, ty, bx, by, 1'b0));
    end
    if (v.end_of_line) begin
      pairs_due.push_back(offset_pair(vx, vy, s2, c2, 1'b1));
      pv_seen = 0; pv_lx = 0; pv_ly = 0; pv_ox = 0; pv_oy = 0;
    end else begin
      pv_ox = pv_lx; pv_oy = pv_ly;
      pv_lx = vx; pv_ly = vy; pv_seen = 2;
    end
  endtask

  // Hand one word to the block; drive at falling edges, accept at the rising edge.
  // Valid stays up after the handshake until the next word or an idle cycle replaces it.
  task automatic send_vertex(input vert_t v);
    while ((idle_mode == IDLE_SEND || idle_mode == IDLE_BOTH) &&
           $urandom_range(99) < 87) begin
      in_valid <= 1'b0;
      vert <= '0;
      @(negedge clk);
    end
    vert <= v;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_offsets(v);
    @(negedge clk);
  endtask

  // Drain: drop valid, wait for all due pairs, then let the block settle before a register write.
  task automatic drain_pairs;
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    vert <= '0;
    while (pairs_due.size() != 0 && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
    repeat (1000) @(negedge clk);
  endtask

  task automatic write_width(input logic [7:0] w);
    drain_pairs();
    cfg_we <= 1'b1;
    cfg_data <= w;
    @(negedge clk);
    cfg_we <= 1'b0;
    pw_width = w;
  endtask

  // Receiver: stall per idle mode, or hold off entirely when asked.
  always @(negedge clk) begin
    if (rst)
      out_stall <= 1'b0;
    else if (hold_recv)
      out_stall <= 1'b1;
    else if (idle_mode == IDLE_RECV || idle_mode == IDLE_BOTH)
      out_stall <= ($urandom_range(99) < 87);
    else
      out_stall <= 1'b0;
  end

  // Check each accepted pair against the oldest due one.
  always @(posedge clk) begin
    pair_t due;
    if (!rst && out_valid && !out_stall) begin
      if (pairs_due.size() == 0) begin
        $error("unexpected pair %h", pair);
        errors++;
      end else begin
        due = pairs_due.pop_front();
        if (pair.top_x !== due.top_x) begin
          $error("top_x expected %0d actual %0d", due.top_x, pair.top_x); errors++;
        end
        if (pair.top_y !== due.top_y) begin
          $error("top_y expected %0d actual %0d", due.top_y, pair.top_y); errors++;
        end
        if (pair.bottom_x !== due.bottom_x) begin
          $error("bottom_x expected %0d actual %0d", due.bottom_x, pair.bottom_x); errors++;
        end
        if (pair.bottom_y !== due.bottom_y) begin
          $error("bottom_y expected %0d actual %0d", due.bottom_y, pair.bottom_y); errors++;
        end
        if (pair.final_pair !== due.final_pair) begin
          $error("final_pair expected %0d actual %0d", due.final_pair, pair.final_pair);
          errors++;
        end
      end
    end
  end

  // Random coordinate: mostly modest, sometimes full range or near the rails.
  function automatic logic [15:0] rand_coord;
    case ($urandom_range(9))
      0, 1: return 16'($urandom);
      2: return $urandom_range(1) ? 16'(32'h7FFF - $urandom_range(40))
                                  : 16'(32'h8000 + $urandom_range(40));
      default: return 16'($urandom_range(400) - 200);
    endcase
  endfunction

  // One polyline of random length; repeats, lone ends and collinear runs mixed in.
  task automatic random_polyline(inout int sent);
    int    len;
    vert_t v, prev;
    longint dx, dy;
    len = $urandom_range(9) == 0 ? 1 : $urandom_range(6, 2);
    prev = '0;
    dx = longint'($urandom_range(20)) - 10;
    dy = longint'($urandom_range(20)) - 10;
    for (int i = 0; i < len; i++) begin
      v.end_of_line = (i == len - 1);
      case ($urandom_range(7))
        0: begin
          v.vert_x = prev.vert_x;
          v.vert_y = prev.vert_y;
        end
        1: begin
          v.vert_x = 16'(prev.vert_x + dx);
          v.vert_y = 16'(prev.vert_y + dy);
        end
        default: begin
          v.vert_x = rand_coord();
          v.vert_y = rand_coord();
        end
      endcase
      if (i == 0 && $urandom_range(9) != 0) begin
        v.vert_x = rand_coord();
        v.vert_y = rand_coord();
      end
      send_vertex(v);
      prev = v;
      sent++;
    end
  endtask

  typedef struct {
    logic [15:0] x;
    logic [15:0] y;
    logic        eol;
    bit          typed;  // expected pair typed in below
    pair_t       want;
  } stim_row_t;

  stim_row_t rows[$];
  int        sent;
  logic [7:0] widths[6] = '{8'd2, 8'd0, 8'd255, 8'd1, 8'd40, 8'd9};

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    vert = '0;
    cfg_we = 1'b0;
    cfg_data = 8'd0;
    hold_recv = 1'b0;
    idle_mode = IDLE_NONE;
    errors = 0;
    pw_width = 8'd2;
    pv_seen = 0; pv_lx = 0; pv_ly = 0; pv_ox = 0; pv_oy = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table: lone ends, repeats, axis segments at the rails, parallel joins.
    rows.push_back('{16'sd5, 16'sd7, 1'b1, 1'b1, '{16'sd5, 16'sd7, 16'sd5, 16'sd7, 1'b1}});
    rows.push_back('{16'h7FFF, 16'h8000, 1'b1, 1'b1,
                     '{16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 1'b1}});
    rows.push_back('{16'sd3, 16'sd3, 1'b0, 1'b0, '0});
    rows.push_back('{16'sd3, 16'sd3, 1'b1, 1'b1, '{16'sd3, 16'sd3, 16'sd3, 16'sd3, 1'b1}});
    rows.push_back('{16'sd0, 16'sd0, 1'b0, 1'b0, '0});
    rows.push_back('{16'sd10, 16'sd0, 1'b0, 1'b0, '0});
    rows.push_back('{16'sd20, 16'sd0, 1'b0, 1'b0, '0});
    rows.push_back('{16'sd20, 16'sd0, 1'b0, 1'b0, '0});
    rows.push_back('{16'sd20, 16'sd10, 1'b0, 1'b0, '0});
    rows.push_back('{16'sd0, 16'sd10, 1'b0, 1'b0, '0});
    rows.push_back('{16'sd0, 16'sd10, 1'b1, 1'b0, '0});
    rows.push_back('{16'h8000, 16'h8000, 1'b0, 1'b0, '0});
    rows.push_back('{16'h7FFF, 16'h7FFF, 1'b0, 1'b0, '0});
    rows.push_back('{16'h8000, 16'h7FFF, 1'b0, 1'b0, '0});
    rows.push_back('{16'h7FFF, 16'h8000, 1'b1, 1'b0, '0});
    rows.push_back('{16'sd1, 16'sd1, 1'b0, 1'b0, '0});
    rows.push_back('{16'sd2, 16'sd2, 1'b0, 1'b0, '0});
    rows.push_back('{16'sd1, 16'sd1, 1'b1, 1'b0, '0});
    rows.push_back('{16'hFFFF, 16'h5555, 1'b0, 1'b0, '0});
    rows.push_back('{16'hAAAA, 16'h0001, 1'b1, 1'b0, '0});

    foreach (rows[i]) begin
      vert_t v;
      int    due_before;
      v.vert_x = rows[i].x;
      v.vert_y = rows[i].y;
      v.end_of_line = rows[i].eol;
      due_before = pairs_due.size();
      send_vertex(v);
      // cross-check the hand-typed pair against the predictor
      if (rows[i].typed && pairs_due.size() > due_before &&
          pairs_due[$] != rows[i].want) begin
        $error("table row %0d disagrees with prediction", i);
        errors++;
      end
    end

    // Pressure: hold the receiver off while words keep coming.
    fork
      begin
        hold_recv = 1'b1;
        repeat (3000) @(negedge clk);
        hold_recv = 1'b0;
      end
      begin
        sent = 0;
        while (sent < 12) random_polyline(sent);
      end
    join

    // Random part, sweeping width settings and idle modes.
    sent = 0;
    foreach (widths[w]) begin
      write_width(widths[w]);
      for (int m = 0; m < 4; m++) begin
        idle_mode = idle_mode_t'(m);
        for (int k = 0; k < 7; k++) random_polyline(sent);
      end
      idle_mode = IDLE_NONE;
    end
    while (sent < 700) begin
      idle_mode = idle_mode_t'($urandom_range(3));
      random_polyline(sent);
    end
    idle_mode = IDLE_NONE;

    drain_pairs();
    if (errors == 0 && pairs_due.size() == 0) begin
      $display("tb passed");
    end else begin
      if (pairs_due.size() != 0) $error("%0d pairs never arrived", pairs_due.size());
      $display("tb failed");
    end
    $finish;
  end

endmodule
